@@ src/qrm_pkg.sv @@
// ----------------------------------------------------------------------------
// qrm_pkg
// Types and constants shared by the quaternion to rotation matrix pipeline.
// ----------------------------------------------------------------------------
package qrm_pkg;

  localparam int unsigned CompWidth = 16;
  localparam int unsigned FracBits  = CompWidth - 2;
  localparam int unsigned ProdWidth = 2 * CompWidth;
  localparam int unsigned NumWidth  = ProdWidth + 3;
  localparam int unsigned RemWidth  = NumWidth - 1;
  localparam int unsigned DenWidth  = ProdWidth + 1;
  localparam int unsigned QuoWidth  = FracBits + 1;
  localparam int unsigned NumLanes  = 9;
  localparam int unsigned NumProds  = 10;

  localparam logic [CompWidth-1:0] OneVal = CompWidth'(1) << FracBits;

  // product slots
  localparam int unsigned PWW = 0;
  localparam int unsigned PXX = 1;
  localparam int unsigned PYY = 2;
  localparam int unsigned PZZ = 3;
  localparam int unsigned PXY = 4;
  localparam int unsigned PWZ = 5;
  localparam int unsigned PXZ = 6;
  localparam int unsigned PWY = 7;
  localparam int unsigned PYZ = 8;
  localparam int unsigned PWX = 9;

  typedef struct packed {
    logic signed [CompWidth-1:0] quat_w;
    logic signed [CompWidth-1:0] quat_x;
    logic signed [CompWidth-1:0] quat_y;
    logic signed [CompWidth-1:0] quat_z;
  } qrm_in_t;

  typedef struct packed {
    logic signed [CompWidth-1:0] m00;
    logic signed [CompWidth-1:0] m01;
    logic signed [CompWidth-1:0] m02;
    logic signed [CompWidth-1:0] m10;
    logic signed [CompWidth-1:0] m11;
    logic signed [CompWidth-1:0] m12;
    logic signed [CompWidth-1:0] m20;
    logic signed [CompWidth-1:0] m21;
    logic signed [CompWidth-1:0] m22;
    logic                        degenerate;
  } qrm_out_t;

  typedef struct packed {
    logic [DenWidth-1:0]                den;
    logic [NumLanes-1:0]                neg;
    logic [NumLanes-1:0][RemWidth-1:0]  rem;
    logic [NumLanes-1:0][QuoWidth-1:0]  quo;
    logic                               degen;
  } qrm_div_t;

endpackage

@@ src/qrm_prep.sv @@
// ----------------------------------------------------------------------------
// qrm_prep
// Input register, component products, numerators and sum of squares, and the
// integer step of the division for all nine entries.
// ----------------------------------------------------------------------------
module qrm_prep (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  qrm_pkg::qrm_in_t  data_i,
  output logic              valid_o,
  output qrm_pkg::qrm_div_t data_o
);

  localparam int unsigned PW = qrm_pkg::ProdWidth;
  localparam int unsigned NW = qrm_pkg::NumWidth;
  localparam int unsigned RW = qrm_pkg::RemWidth;
  localparam int unsigned DW = qrm_pkg::DenWidth;
  localparam int unsigned NL = qrm_pkg::NumLanes;
  localparam int unsigned NP = qrm_pkg::NumProds;

  logic [2:0] valid_q;
  qrm_pkg::qrm_in_t a_q;
  logic signed [PW-1:0] p_d [NP];
  logic signed [PW-1:0] p_q [NP];
  logic signed [NW-1:0] e [NP];
  logic signed [NW-1:0] num_d [NL];
  logic signed [NW-1:0] num_q [NL];
  logic signed [NW-1:0] sum_d;
  logic [DW-1:0] den_q;
  logic degen_q;
  qrm_pkg::qrm_div_t div_d, div_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_q <= {valid_q[1:0], valid_i};
      valid_o <= valid_q[2];
    end
  end

  // products
  always_comb begin
    p_d[qrm_pkg::PWW] = a_q.quat_w * a_q.quat_w;
    p_d[qrm_pkg::PXX] = a_q.quat_x * a_q.quat_x;
    p_d[qrm_pkg::PYY] = a_q.quat_y * a_q.quat_y;
    p_d[qrm_pkg::PZZ] = a_q.quat_z * a_q.quat_z;
    p_d[qrm_pkg::PXY] = a_q.quat_x * a_q.quat_y;
    p_d[qrm_pkg::PWZ] = a_q.quat_w * a_q.quat_z;
    p_d[qrm_pkg::PXZ] = a_q.quat_x * a_q.quat_z;
    p_d[qrm_pkg::PWY] = a_q.quat_w * a_q.quat_y;
    p_d[qrm_pkg::PYZ] = a_q.quat_y * a_q.quat_z;
    p_d[qrm_pkg::PWX] = a_q.quat_w * a_q.quat_x;
  end

  // numerators and sum of squares
  always_comb begin
    for (int i = 0; i < NP; i++) begin
      e[i] = {{(NW-PW){p_q[i][PW-1]}}, p_q[i]};
    end
    sum_d = e[qrm_pkg::PWW] + e[qrm_pkg::PXX] + e[qrm_pkg::PYY] + e[qrm_pkg::PZZ];
    num_d[0] = e[qrm_pkg::PWW] + e[qrm_pkg::PXX] - e[qrm_pkg::PYY] - e[qrm_pkg::PZZ];
    num_d[1] = (e[qrm_pkg::PXY] - e[qrm_pkg::PWZ]) <<< 1;
    num_d[2] = (e[qrm_pkg::PXZ] + e[qrm_pkg::PWY]) <<< 1;
    num_d[3] = (e[qrm_pkg::PXY] + e[qrm_pkg::PWZ]) <<< 1;
    num_d[4] = e[qrm_pkg::PWW] - e[qrm_pkg::PXX] + e[qrm_pkg::PYY] - e[qrm_pkg::PZZ];
    num_d[5] = (e[qrm_pkg::PYZ] - e[qrm_pkg::PWX]) <<< 1;
    num_d[6] = (e[qrm_pkg::PXZ] - e[qrm_pkg::PWY]) <<< 1;
    num_d[7] = (e[qrm_pkg::PYZ] + e[qrm_pkg::PWX]) <<< 1;
    num_d[8] = e[qrm_pkg::PWW] - e[qrm_pkg::PXX] - e[qrm_pkg::PYY] + e[qrm_pkg::PZZ];
  end

  // integer quotient bit and remainder clamp
  always_comb begin
    logic [RW-1:0] mag;
    logic [RW-1:0] d;
    mag = '0;
    d = {1'b0, den_q};
    div_d.den = den_q;
    div_d.degen = degen_q;
    for (int i = 0; i < NL; i++) begin
      div_d.neg[i] = num_q[i][NW-1];
      mag = num_q[i][NW-1] ? RW'(-num_q[i]) : RW'(num_q[i]);
      div_d.quo[i] = '0;
      if (mag >= d) begin
        div_d.quo[i][0] = 1'b1;
        mag = mag - d;
      end
      if (mag >= d) begin
        mag = d - RW'(1);
      end
      div_d.rem[i] = mag;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_q <= data_i;
      for (int i = 0; i < NP; i++) begin
        p_q[i] <= p_d[i];
      end
      for (int i = 0; i < NL; i++) begin
        num_q[i] <= num_d[i];
      end
      den_q   <= DW'(sum_d);
      degen_q <= (sum_d == '0);
      div_q   <= div_d;
    end
  end

  assign data_o = div_q;

endmodule

@@ src/qrm_div_stage.sv @@
// ----------------------------------------------------------------------------
// qrm_div_stage
// One restoring division step, one quotient bit for each of the nine lanes.
// ----------------------------------------------------------------------------
module qrm_div_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  qrm_pkg::qrm_div_t data_i,
  output logic              valid_o,
  output qrm_pkg::qrm_div_t data_o
);

  localparam int unsigned RW = qrm_pkg::RemWidth;
  localparam int unsigned QW = qrm_pkg::QuoWidth;

  qrm_pkg::qrm_div_t data_d;

  always_comb begin
    logic [RW-1:0] r2;
    logic [RW-1:0] d;
    logic          ge;
    r2 = '0;
    ge = 1'b0;
    d = {1'b0, data_i.den};
    data_d = data_i;
    for (int i = 0; i < qrm_pkg::NumLanes; i++) begin
      r2 = {data_i.rem[i][RW-2:0], 1'b0};
      ge = (r2 >= d);
      data_d.rem[i] = ge ? (r2 - d) : r2;
      data_d.quo[i] = {data_i.quo[i][QW-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_o <= data_d;
    end
  end

endmodule

@@ src/qrm_final.sv @@
// ----------------------------------------------------------------------------
// qrm_final
// Rounding, saturation, sign and zero quaternion handling; output register.
// ----------------------------------------------------------------------------
module qrm_final (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  qrm_pkg::qrm_div_t data_i,
  output logic              valid_o,
  output qrm_pkg::qrm_out_t data_o
);

  localparam int unsigned CW = qrm_pkg::CompWidth;
  localparam int unsigned RW = qrm_pkg::RemWidth;
  localparam int unsigned NL = qrm_pkg::NumLanes;

  logic [CW-1:0] val [NL];
  qrm_pkg::qrm_out_t data_d;

  always_comb begin
    logic [RW-1:0] r2;
    logic [RW-1:0] d;
    logic [CW-1:0] q;
    r2 = '0;
    q = '0;
    d = {1'b0, data_i.den};
    for (int i = 0; i < NL; i++) begin
      r2 = {data_i.rem[i][RW-2:0], 1'b0};
      q = {1'b0, data_i.quo[i]} + CW'(r2 >= d);
      if (q > qrm_pkg::OneVal) begin
        q = qrm_pkg::OneVal;
      end
      if (data_i.degen) begin
        val[i] = (i % 4 == 0) ? qrm_pkg::OneVal : '0;
      end else begin
        val[i] = data_i.neg[i] ? (-q) : q;
      end
    end
    data_d.m00 = val[0];
    data_d.m01 = val[1];
    data_d.m02 = val[2];
    data_d.m10 = val[3];
    data_d.m11 = val[4];
    data_d.m12 = val[5];
    data_d.m20 = val[6];
    data_d.m21 = val[7];
    data_d.m22 = val[8];
    data_d.degenerate = data_i.degen;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_o <= data_d;
    end
  end

endmodule

@@ src/quaternion_to_rotation_matrix.sv @@
// order: prep registers, division stages, output register
// throughput: one item per cycle; the whole pipeline advances together and
// holds while the output register is full and not taken
// the 14 fractional quotient bits come from 14 restoring division stages
// reset: asynchronous active low, clears all valid bits; no item in flight
// ----------------------------------------------------------------------------
// quaternion_to_rotation_matrix
// Normalizes a Q1.14 quaternion and gives its 3x3 rotation matrix in Q1.14.
// ----------------------------------------------------------------------------
module quaternion_to_rotation_matrix (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  qrm_pkg::qrm_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output qrm_pkg::qrm_out_t out_data_o
);

  localparam int unsigned NS = qrm_pkg::FracBits;

  logic en;
  logic              v [NS+1];
  qrm_pkg::qrm_div_t d [NS+1];

  assign en = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  qrm_prep u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .data_i  (in_data_i),
    .valid_o (v[0]),
    .data_o  (d[0])
  );

  for (genvar g = 0; g < NS; g++) begin : g_div
    qrm_div_stage u_div (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (v[g]),
      .data_i  (d[g]),
      .valid_o (v[g+1]),
      .data_o  (d[g+1])
    );
  end

  qrm_final u_final (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v[NS]),
    .data_i  (d[NS]),
    .valid_o (out_valid_o),
    .data_o  (out_data_o)
  );

endmodule

@@ src/qrm_checker.sv @@
// ----------------------------------------------------------------------------
// qrm_checker
// Port level checks for the quaternion to rotation matrix block.
// ----------------------------------------------------------------------------
module qrm_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_ready_o,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input qrm_pkg::qrm_out_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result item changed while stalled");

  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input blocked with empty output");

  a_degen_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.degenerate |->
      out_data_o.m00 == qrm_pkg::OneVal && out_data_o.m11 == qrm_pkg::OneVal &&
      out_data_o.m22 == qrm_pkg::OneVal && out_data_o.m01 == '0 &&
      out_data_o.m12 == '0 && out_data_o.m20 == '0)
    else $error("zero quaternion without identity");

  a_diag_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      out_data_o.m00 <= $signed(qrm_pkg::OneVal) &&
      out_data_o.m00 >= -$signed(qrm_pkg::OneVal) &&
      out_data_o.m11 <= $signed(qrm_pkg::OneVal) &&
      out_data_o.m11 >= -$signed(qrm_pkg::OneVal))
    else $error("entry beyond unit range");

endmodule

bind quaternion_to_rotation_matrix qrm_checker u_qrm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives quaternions into the rotation matrix pipeline and checks every
// matrix against a predictor that divides each quadratic form by the sum of
// squares, rounding to nearest with ties away from zero and clamping to one.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int NumDirected = 16;
  localparam logic signed [15:0] Pos1 = 16'sd16384;
  localparam logic signed [15:0] Neg2 = 16'sh8000;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  qrm_pkg::qrm_in_t  in_data_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  qrm_pkg::qrm_out_t out_data_o;

  qrm_pkg::qrm_out_t pending_mats[$];
  int                mismatches = 0;
  int                send_idle_pct = 0;
  int                recv_stall_pct = 0;
  bit                recv_hold = 1'b0;
  bit                check_known[NumDirected];
  qrm_pkg::qrm_in_t  quat_table[NumDirected];
  qrm_pkg::qrm_out_t mat_table[NumDirected];

  quaternion_to_rotation_matrix uut (.*);

  always #5 clk_i = ~clk_i;

  initial begin
    #50ms;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic logic signed [15:0] norm_ratio(longint num, longint den);
    bit      neg;
    longint  mag;
    longint  q;
    neg = num < 0;
    mag = neg ? -num : num;
    q = 0;
    if (mag >= den) begin
      q = 1;
      mag -= den;
    end
    if (mag >= den) mag = den - 1;
    for (int i = 0; i < qrm_pkg::FracBits; i++) begin
      mag = mag << 1;
      q = q << 1;
      if (mag >= den) begin
        mag -= den;
        q |= 1;
      end
    end
    if ((mag << 1) >= den) q++;
    if (q > 16384) q = 16384;
    return neg ? 16'(-q) : 16'(q);
  endfunction

  function automatic qrm_pkg::qrm_out_t rotation_of(qrm_pkg::qrm_in_t q);
    qrm_pkg::qrm_out_t r;
    longint            w, x, y, z, ww, xx, yy, zz, s;
    w = q.quat_w; x = q.quat_x; y = q.quat_y; z = q.quat_z;
    ww = w * w; xx = x * x; yy = y * y; zz = z * z;
    s = ww + xx + yy + zz;
    r = '0;
    if (s == 0) begin
      r.m00 = Pos1; r.m11 = Pos1; r.m22 = Pos1;
      r.degenerate = 1'b1;
      return r;
    end
    r.m00 = norm_ratio(ww + xx - yy - zz, s);
    r.m01 = norm_ratio(2 * (x * y - w * z), s);
    r.m02 = norm_ratio(2 * (x * z + w * y), s);
    r.m10 = norm_ratio(2 * (x * y + w * z), s);
    r.m11 = norm_ratio(ww - xx + yy - zz, s);
    r.m12 = norm_ratio(2 * (y * z - w * x), s);
    r.m20 = norm_ratio(2 * (x * z - w * y), s);
    r.m21 = norm_ratio(2 * (y * z + w * x), s);
    r.m22 = norm_ratio(ww - xx - yy + zz, s);
    return r;
  endfunction

  function automatic qrm_pkg::qrm_in_t quat(int w, int x, int y, int z);
    qrm_pkg::qrm_in_t q;
    q.quat_w = 16'(w); q.quat_x = 16'(x); q.quat_y = 16'(y); q.quat_z = 16'(z);
    return q;
  endfunction

  function automatic qrm_pkg::qrm_out_t ident_mat(bit degen);
    qrm_pkg::qrm_out_t r;
    r = '0;
    r.m00 = Pos1; r.m11 = Pos1; r.m22 = Pos1;
    r.degenerate = degen;
    return r;
  endfunction

  function automatic qrm_pkg::qrm_in_t random_quat();
    qrm_pkg::qrm_in_t q;
    int               mode;
    mode = $urandom_range(0, 9);
    q = qrm_pkg::qrm_in_t'({$urandom, $urandom});
    if (mode < 3) begin
      q.quat_w = 16'($signed(q.quat_w) >>> $urandom_range(0, 14));
      q.quat_x = 16'($signed(q.quat_x) >>> $urandom_range(0, 14));
      q.quat_y = 16'($signed(q.quat_y) >>> $urandom_range(0, 14));
      q.quat_z = 16'($signed(q.quat_z) >>> $urandom_range(0, 14));
    end else if (mode == 3) begin
      if ($urandom_range(0, 1)) q.quat_x = '0;
      if ($urandom_range(0, 1)) q.quat_y = '0;
      if ($urandom_range(0, 1)) q.quat_z = '0;
      if ($urandom_range(0, 3) == 0) q.quat_w = '0;
    end else if (mode == 4) begin
      q.quat_w = 16'($urandom_range(0, 2) - 1);
      q.quat_x = 16'($urandom_range(0, 2) - 1);
      q.quat_y = 16'($urandom_range(0, 2) - 1);
      q.quat_z = 16'($urandom_range(0, 2) - 1);
    end else if (mode == 5) begin
      q = $urandom_range(0, 1) ? quat(Neg2, Neg2, Neg2, Neg2) : quat(32767, 32767, 32767, 32767);
      if ($urandom_range(0, 1)) q.quat_y = ~q.quat_y;
    end
    return q;
  endfunction

  task automatic send_item(qrm_pkg::qrm_in_t q);
    while ($urandom_range(1, 100) <= send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= q;
    pending_mats.push_back(rotation_of(q));
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_mats.size() != 0) @(posedge clk_i);
  endtask

  task automatic run_random(int n, int idle_pct, int stall_pct);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < n; i++) send_item(random_quat());
  endtask

  // out_ready is decided each edge from the stall rate or a long hold
  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) begin
      if (pending_mats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected matrix %h", out_data_o);
      end else if (out_data_o !== pending_mats[0]) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected %h actual %h", pending_mats[0], out_data_o);
        void'(pending_mats.pop_front());
      end else begin
        void'(pending_mats.pop_front());
      end
    end
    out_ready_i <= !recv_hold && ($urandom_range(1, 100) > recv_stall_pct);
  end

  initial begin
    recv_hold = 1'b1;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    recv_hold = 1'b0;
    quat_table = '{quat(0, 0, 0, 0), quat(Pos1, 0, 0, 0), quat(1, 0, 0, 0),
                   quat(Neg2, 0, 0, 0), quat(32767, 0, 0, 0), quat(0, Pos1, 0, 0),
                   quat(0, 0, Pos1, 0), quat(0, 0, 0, Pos1), quat(0, 0, 0, Neg2),
                   quat(Neg2, Neg2, Neg2, Neg2), quat(32767, 32767, 32767, 32767),
                   quat(32767, Neg2, 32767, Neg2), quat(Pos1, Pos1, 0, 0),
                   quat(-1, -1, -1, -1), quat(0, 1, -1, 0), quat(11585, 0, 11585, 0)};
    check_known = '{1, 1, 1, 1, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0};
    mat_table[0] = ident_mat(1'b1);
    for (int i = 1; i < 5; i++) mat_table[i] = ident_mat(1'b0);
    for (int i = 0; i < NumDirected; i++) begin
      if (check_known[i] && rotation_of(quat_table[i]) !== mat_table[i]) begin
        mismatches++;
        if (mismatches <= 10) $display("directed row %0d predictor disagrees", i);
      end
      send_item(quat_table[i]);
    end
    wait_drained();
    run_random(400, 0, 0);
    run_random(300, 50, 0);
    run_random(300, 0, 50);
    run_random(250, 6, 6);
    // long receiver hold so the pipeline fills and backs up
    fork
      begin
        recv_hold = 1'b1;
        repeat (80) @(posedge clk_i);
        recv_hold = 1'b0;
      end
      run_random(60, 0, 0);
    join
    wait_drained();
    run_random(140, 0, 0);
    wait_drained();
    repeat (40) @(posedge clk_i);
    if (mismatches == 0 && pending_mats.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
